// File: rtl/dtfd_pkg.sv
package dtfd_pkg;

  // Largest digit count after the decimal point.
  localparam int MAX_FRACTION_DIGITS = 15;

  // Fixed-point layout of the magnitude: 63 integer bits over 104 fraction bits.
  localparam int FRAC_BITS = 104;
  localparam int WW        = 167;
  // Scaled fraction: up to 50 integer bits over the same 104 fraction bits.
  localparam int XW        = 154;
  localparam int FINT_W    = 50;
  localparam int BIN_W     = 64;
  localparam int BCD_W     = 80;
  localparam int NORM_MAX  = 52;

  // Exponent field thresholds.
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_ERR_MIN  = 11'd1086;
  localparam logic [10:0] EXP_FRAC_MIN = 11'd971;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MUL  = 13'b0000000000010,
    S_NORM = 13'b0000000000100,
    S_RND  = 13'b0000000001000,
    S_RND2 = 13'b0000000010000,
    S_CHK  = 13'b0000000100000,
    S_CONV = 13'b0000001000000,
    S_SIGN = 13'b0000010000000,
    S_SKIP = 13'b0000100000000,
    S_INT  = 13'b0001000000000,
    S_DOT  = 13'b0010000000000,
    S_FRAC = 13'b0100000000000,
    S_ERR  = 13'b1000000000000
  } state_t;

  // Powers of ten for the carry check on the rounded fraction.
  function automatic logic [FINT_W-1:0] pow10(input logic [3:0] d);
    logic [FINT_W-1:0] p;
    case (d)
      4'd0:    p = 50'd1;
      4'd1:    p = 50'd10;
      4'd2:    p = 50'd100;
      4'd3:    p = 50'd1000;
      4'd4:    p = 50'd10000;
      4'd5:    p = 50'd100000;
      4'd6:    p = 50'd1000000;
      4'd7:    p = 50'd10000000;
      4'd8:    p = 50'd100000000;
      4'd9:    p = 50'd1000000000;
      4'd10:   p = 50'd10000000000;
      4'd11:   p = 50'd100000000000;
      4'd12:   p = 50'd1000000000000;
      4'd13:   p = 50'd10000000000000;
      4'd14:   p = 50'd100000000000000;
      default: p = 50'd1000000000000000;
    endcase
    return p;
  endfunction

  // Digit counts above the limit are treated as the limit.
  function automatic logic [3:0] clamp_digits(input logic [3:0] d);
    logic [3:0] r;
    if (32'(d) > MAX_FRACTION_DIGITS) begin
      r = 4'(MAX_FRACTION_DIGITS);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// File: rtl/double_to_fixed_decimal_text.sv
// Channel  Direction  Ports                            Contents
// in       slave      in_tvalid/in_tready/in_tdata     one binary64 value per beat
// out      master     out_tvalid/out_tready/out_t*     one ASCII character per beat
// cfg      write      cfg_valid/cfg_ready/cfg_data     digits after the point
//
// One value is worked at a time. A value is loaded, its fraction is scaled by
// ten once per fraction digit, shifted to normalize it, rounded in the states
// S_RND, S_RND2 and S_CHK, converted in the bit-serial BCD converters, and
// stripped of leading zeros; then its characters are sent while the output is
// not stalled. With no fraction digits the integer part is rounded at load and
// goes straight to the converters. An error value sends a single NUL character
// flagged as an error. Reset is synchronous and sets the digit count to 15; a stalled output holds the beat.
module double_to_fixed_decimal_text (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast,  // last_char
  output logic        out_tuser,  // [0] error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // [3:0] fraction_digits
);

  dtfd_pkg::state_t state_r, state_nxt;

  logic [3:0]                    digits_r, digits_nxt, dig_cfg_r;
  logic                          neg_r, neg_nxt;
  logic [63:0]                   ipart_r, ipart_nxt;
  logic [dtfd_pkg::XW-1:0]       x_r, x_nxt;
  logic [3:0]                    mcnt_r, mcnt_nxt;
  logic [5:0]                    ncnt_r, ncnt_nxt;
  logic [54:0]                   s_r, s_nxt;
  logic [dtfd_pkg::FINT_W-1:0]   fint_r, fint_nxt;
  logic [4:0]                    idx_r, idx_nxt;
  logic                          start_r, start_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_err_r, out_err_nxt;

  logic [10:0]                   expf;
  logic [6:0]                    wsh;
  logic [dtfd_pkg::WW-1:0]       w;
  logic                          tiny;
  logic                          can_load;
  logic [53:0]                   pm;
  logic                          rinc;
  logic [55:0]                   sr;
  logic [55:0]                   fsh;
  logic                          idone, fdone;
  logic [dtfd_pkg::BCD_W-1:0]    ibcd, fbcd;
  logic [3:0]                    idig, fdig;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_cfg_r <= 4'(dtfd_pkg::MAX_FRACTION_DIGITS);
    end else if (cfg_valid && cfg_ready) begin
      dig_cfg_r <= cfg_data;
    end
  end

  // Unpack the input and align the magnitude on a fixed binary point.
  assign expf = in_tdata[62:52];
  assign tiny = (expf < dtfd_pkg::EXP_FRAC_MIN);
  assign wsh  = 7'(expf - dtfd_pkg::EXP_FRAC_MIN);
  assign w    = {114'b0, 1'b1, in_tdata[51:0]} << wsh;

  assign can_load = !out_valid_r || out_tready;

  // Round the scaled fraction to 53 significant bits, nearest even.
  assign rinc = x_r[100] & ((|x_r[99:0]) | x_r[101]);
  assign pm   = {1'b0, x_r[153:101]} + {53'b0, rinc};

  // Round the sum with one half to 53 significant bits, then truncate.
  always_comb begin
    if (s_r[54]) begin
      sr = {1'b0, s_r[54:2], 2'b00} +
           {53'b0, s_r[1] & (s_r[0] | s_r[2]), 2'b00};
    end else if (s_r[53]) begin
      sr = {2'b0, s_r[53:1], 1'b0} + {54'b0, s_r[0] & s_r[1], 1'b0};
    end else begin
      sr = {1'b0, s_r};
    end
    fsh = sr >> ({1'b0, ncnt_r} + 7'd3);
  end

  assign idig = ibcd[{idx_r, 2'b00} +: 4];
  assign fdig = fbcd[{idx_r, 2'b00} +: 4];

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = digits_r;
    neg_nxt       = neg_r;
    ipart_nxt     = ipart_r;
    x_nxt         = x_r;
    mcnt_nxt      = mcnt_r;
    ncnt_nxt      = ncnt_r;
    s_nxt         = s_r;
    fint_nxt      = fint_r;
    idx_nxt       = idx_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    in_tready     = 1'b0;

    case (state_r)
      dtfd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          digits_nxt = dtfd_pkg::clamp_digits(dig_cfg_r);
          neg_nxt    = in_tdata[63] && (in_tdata[62:0] != 63'd0);
          fint_nxt   = '0;
          ncnt_nxt   = '0;
          mcnt_nxt   = dtfd_pkg::clamp_digits(dig_cfg_r);
          if (tiny) begin
            ipart_nxt = '0;
            x_nxt     = '0;
          end else begin
            ipart_nxt = {1'b0, w[dtfd_pkg::WW-1:dtfd_pkg::FRAC_BITS]};
            x_nxt     = {50'b0, w[dtfd_pkg::FRAC_BITS-1:0]};
          end
          if (expf == dtfd_pkg::EXP_ALL_ONES || expf >= dtfd_pkg::EXP_ERR_MIN) begin
            state_nxt = dtfd_pkg::S_ERR;
          end else if (dtfd_pkg::clamp_digits(dig_cfg_r) == 4'd0) begin
            if (!tiny && w[dtfd_pkg::FRAC_BITS-1]) begin
              ipart_nxt = {1'b0, w[dtfd_pkg::WW-1:dtfd_pkg::FRAC_BITS]} + 64'd1;
            end
            start_nxt = 1'b1;
            state_nxt = dtfd_pkg::S_CONV;
          end else begin
            state_nxt = dtfd_pkg::S_MUL;
          end
        end
      end

      // Scale the fraction by ten once per cycle.
      dtfd_pkg::S_MUL: begin
        x_nxt    = {x_r[dtfd_pkg::XW-4:0], 3'b000} + {x_r[dtfd_pkg::XW-2:0], 1'b0};
        mcnt_nxt = mcnt_r - 4'd1;
        if (mcnt_r == 4'd1) begin
          state_nxt = dtfd_pkg::S_NORM;
        end
      end

      // Shift left one bit a cycle until the leading one reaches the top or 52 bits have shifted.
      dtfd_pkg::S_NORM: begin
        if (x_r[dtfd_pkg::XW-1] || 32'(ncnt_r) == dtfd_pkg::NORM_MAX) begin
          state_nxt = dtfd_pkg::S_RND;
        end else begin
          x_nxt    = {x_r[dtfd_pkg::XW-2:0], 1'b0};
          ncnt_nxt = ncnt_r + 6'd1;
        end
      end

      dtfd_pkg::S_RND: begin
        if (!x_r[dtfd_pkg::XW-1]) begin
          fint_nxt  = '0;
          start_nxt = 1'b1;
          state_nxt = dtfd_pkg::S_CONV;
        end else begin
          s_nxt     = {1'b0, pm} + (55'd1 << ({1'b0, ncnt_r} + 7'd2));
          state_nxt = dtfd_pkg::S_RND2;
        end
      end

      dtfd_pkg::S_RND2: begin
        fint_nxt  = fsh[dtfd_pkg::FINT_W-1:0];
        state_nxt = dtfd_pkg::S_CHK;
      end

      // A fraction that reaches the full scale carries into the integer.
      dtfd_pkg::S_CHK: begin
        if (fint_r >= dtfd_pkg::pow10(digits_r)) begin
          fint_nxt  = '0;
          ipart_nxt = ipart_r + 64'd1;
        end
        start_nxt = 1'b1;
        state_nxt = dtfd_pkg::S_CONV;
      end

      dtfd_pkg::S_CONV: begin
        idx_nxt = 5'd19;
        if (idone && fdone) begin
          state_nxt = neg_r ? dtfd_pkg::S_SIGN : dtfd_pkg::S_SKIP;
        end
      end

      dtfd_pkg::S_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dtfd_pkg::CH_MINUS;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          state_nxt     = dtfd_pkg::S_SKIP;
        end
      end

      // Drop leading zeros of the integer part, keeping at least one digit.
      dtfd_pkg::S_SKIP: begin
        if (idx_r != 5'd0 && idig == 4'd0) begin
          idx_nxt = idx_r - 5'd1;
        end else begin
          state_nxt = dtfd_pkg::S_INT;
        end
      end

      dtfd_pkg::S_INT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dtfd_pkg::CH_ZERO + {4'b0, idig};
          out_last_nxt  = (idx_r == 5'd0) && (digits_r == 4'd0);
          out_err_nxt   = 1'b0;
          if (idx_r == 5'd0) begin
            state_nxt = (digits_r == 4'd0) ? dtfd_pkg::S_IDLE : dtfd_pkg::S_DOT;
          end else begin
            idx_nxt = idx_r - 5'd1;
          end
        end
      end

      dtfd_pkg::S_DOT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dtfd_pkg::CH_DOT;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          idx_nxt       = {1'b0, digits_r} - 5'd1;
          state_nxt     = dtfd_pkg::S_FRAC;
        end
      end

      dtfd_pkg::S_FRAC: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dtfd_pkg::CH_ZERO + {4'b0, fdig};
          out_last_nxt  = (idx_r == 5'd0);
          out_err_nxt   = 1'b0;
          if (idx_r == 5'd0) begin
            state_nxt = dtfd_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r - 5'd1;
          end
        end
      end

      dtfd_pkg::S_ERR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dtfd_pkg::CH_NUL;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = dtfd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dtfd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtfd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
    end
    digits_r   <= digits_nxt;
    neg_r      <= neg_nxt;
    ipart_r    <= ipart_nxt;
    x_r        <= x_nxt;
    mcnt_r     <= mcnt_nxt;
    ncnt_r     <= ncnt_nxt;
    s_r        <= s_nxt;
    fint_r     <= fint_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Integer and fraction converters run side by side.
  dtfd_bcd u_ibcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .bin   (ipart_r),
    .done  (idone),
    .bcd   (ibcd)
  );

  dtfd_bcd u_fbcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .bin   ({14'b0, fint_r}),
    .done  (fdone),
    .bcd   (fbcd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// File: rtl/dtfd_bcd.sv
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module dtfd_bcd (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dtfd_pkg::BIN_W-1:0] bin,
  output logic                       done,
  output logic [dtfd_pkg::BCD_W-1:0] bcd
);

  logic [dtfd_pkg::BIN_W-1:0] sh_r, sh_nxt;
  logic [dtfd_pkg::BCD_W-1:0] bcd_r, bcd_nxt, adj;
  logic [6:0]                 cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < dtfd_pkg::BCD_W / 4; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = bin;
      bcd_nxt = '0;
      cnt_nxt = 7'(dtfd_pkg::BIN_W);
    end else if (cnt_r != 7'd0) begin
      sh_nxt   = {sh_r[dtfd_pkg::BIN_W-2:0], 1'b0};
      bcd_nxt  = {adj[dtfd_pkg::BCD_W-2:0], sh_r[dtfd_pkg::BIN_W-1]};
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
